/* hdl/psd_pkg.sv */
// Shared types and fixed field widths of the point-to-segment distance block.
package psd_pkg;

    // Result field widths are fixed by the word format.
    localparam int POS_W  = 17;
    localparam int DIST_W = 33;

    // Which of the three projection cases a word falls into.
    typedef struct packed {
        logic deg;       // zero-length segment
        logic hi;        // projection at or beyond the end point
        logic interior;  // projection strictly inside the segment
    } psd_flags_t;

endpackage

/* hdl/psd_query_if.sv */
// Query channel: a point and a segment, with valid/ready handshake.
interface psd_query_if #(
    parameter int COORD_BITS = 24
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source (
        output valid, point_x, point_y, start_x, start_y, end_x, end_y,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, start_x, start_y, end_x, end_y,
        output ready
    );
endinterface

/* hdl/psd_result_if.sv */
// Result channel: clamped position, distance and degenerate flag.
interface psd_result_if ();
    logic                        valid;
    logic                        ready;
    logic [psd_pkg::POS_W-1:0]   position;
    logic [psd_pkg::DIST_W-1:0]  distance;
    logic                        degenerate;

    modport source (
        output valid, position, distance, degenerate,
        input  ready
    );
    modport sink (
        input  valid, position, distance, degenerate,
        output ready
    );
endinterface

/* hdl/psd_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with the position divide alongside.
module psd_div #(
    parameter int PW = 51,
    parameter int QW = 67,
    parameter int PF = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                start_valid,
    input  logic [PW-1:0]       remainder,
    input  logic [QW-1:0]       dividend_low,
    input  logic [PW-1:0]       divisor,
    input  logic [PW-1:0]       pos_remainder,
    input  psd_pkg::psd_flags_t flags,
    output logic                done_valid,
    output logic [QW-1:0]       quotient,
    output logic [PF-1:0]       pos_quotient,
    output psd_pkg::psd_flags_t done_flags
);

    localparam int NS = (QW > PF) ? QW : PF;

    wire                      vld_cur   [NS];
    wire [PW-1:0]             rem_cur   [NS];
    wire [QW-1:0]             low_cur   [NS];
    wire [PW-1:0]             den_cur   [NS];
    wire [PW-1:0]             posr_cur  [NS];
    wire [PF-1:0]             posq_cur  [NS];
    wire psd_pkg::psd_flags_t flags_cur [NS];

    wire [PW-1:0]             rem_next  [NS];
    wire [QW-1:0]             low_next  [NS];
    wire [PW-1:0]             posr_next [NS];
    wire [PF-1:0]             posq_next [NS];

    logic                     vld_reg   [NS];
    logic [PW-1:0]            rem_reg   [NS];
    logic [QW-1:0]            low_reg   [NS];
    logic [PW-1:0]            den_reg   [NS];
    logic [PW-1:0]            posr_reg  [NS];
    logic [PF-1:0]            posq_reg  [NS];
    psd_pkg::psd_flags_t      flags_reg [NS];

    for (genvar k = 0; k < NS; k++) begin : g_step
        if (k == 0) begin : g_head
            assign vld_cur[k]   = start_valid;
            assign rem_cur[k]   = remainder;
            assign low_cur[k]   = dividend_low;
            assign den_cur[k]   = divisor;
            assign posr_cur[k]  = pos_remainder;
            assign posq_cur[k]  = '0;
            assign flags_cur[k] = flags;
        end
        else begin : g_body
            assign vld_cur[k]   = vld_reg[k-1];
            assign rem_cur[k]   = rem_reg[k-1];
            assign low_cur[k]   = low_reg[k-1];
            assign den_cur[k]   = den_reg[k-1];
            assign posr_cur[k]  = posr_reg[k-1];
            assign posq_cur[k]  = posq_reg[k-1];
            assign flags_cur[k] = flags_reg[k-1];
        end

        // The next dividend bit comes off the top of the low word while the
        // quotient bit shifts in at the bottom.
        if (k < QW) begin : g_div
            logic [PW:0] trial;
            logic        take;
            assign trial       = {rem_cur[k], low_cur[k][QW-1]};
            assign take        = trial >= {1'b0, den_cur[k]};
            assign rem_next[k] = take ? PW'(trial - {1'b0, den_cur[k]}) : trial[PW-1:0];
            assign low_next[k] = {low_cur[k][QW-2:0], take};
        end
        else begin : g_div_hold
            assign rem_next[k] = rem_cur[k];
            assign low_next[k] = low_cur[k];
        end

        // For an interior projection the divisor is the squared length.
        if (k < PF) begin : g_pos
            logic [PW:0] ptrial;
            logic        ptake;
            assign ptrial       = {posr_cur[k], 1'b0};
            assign ptake        = ptrial >= {1'b0, den_cur[k]};
            assign posr_next[k] = ptake ? PW'(ptrial - {1'b0, den_cur[k]})
                                        : ptrial[PW-1:0];
            assign posq_next[k] = {posq_cur[k][PF-2:0], ptake};
        end
        else begin : g_pos_hold
            assign posr_next[k] = posr_cur[k];
            assign posq_next[k] = posq_cur[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NS; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < NS; k++)
            begin
                vld_reg[k] <= vld_cur[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NS; k++)
            begin
                rem_reg[k]   <= rem_next[k];
                low_reg[k]   <= low_next[k];
                den_reg[k]   <= den_cur[k];
                posr_reg[k]  <= posr_next[k];
                posq_reg[k]  <= posq_next[k];
                flags_reg[k] <= flags_cur[k];
            end
        end
    end

    assign done_valid   = vld_reg[NS-1];
    assign quotient     = low_reg[NS-1];
    assign pos_quotient = posq_reg[NS-1];
    assign done_flags   = flags_reg[NS-1];

endmodule

/* hdl/psd_sqrt.sv */
// Pipelined digit-by-digit integer square root, one root bit per stage.
module psd_sqrt #(
    parameter int QW = 67,
    parameter int SW = 34,
    parameter int TW = 18
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          start_valid,
    input  logic [QW-1:0] radicand,
    input  logic [TW-1:0] tag,
    output logic          done_valid,
    output logic [SW-1:0] root,
    output logic [TW-1:0] done_tag
);

    localparam int RW = SW + 2;
    localparam int AW = 2 * SW;

    wire          vld_cur  [SW];
    wire [RW-1:0] rem_cur  [SW];
    wire [SW-1:0] root_cur [SW];
    wire [AW-1:0] rad_cur  [SW];
    wire [TW-1:0] tag_cur  [SW];

    wire [RW-1:0] rem_next  [SW];
    wire [SW-1:0] root_next [SW];

    logic          vld_reg  [SW];
    logic [RW-1:0] rem_reg  [SW];
    logic [SW-1:0] root_reg [SW];
    logic [AW-1:0] rad_reg  [SW];
    logic [TW-1:0] tag_reg  [SW];

    for (genvar k = 0; k < SW; k++) begin : g_step
        logic [RW-1:0] part;
        logic [RW-1:0] trial;
        logic          take;

        if (k == 0) begin : g_head
            assign vld_cur[k]  = start_valid;
            assign rem_cur[k]  = '0;
            assign root_cur[k] = '0;
            assign rad_cur[k]  = AW'(radicand);
            assign tag_cur[k]  = tag;
        end
        else begin : g_body
            assign vld_cur[k]  = vld_reg[k-1];
            assign rem_cur[k]  = rem_reg[k-1];
            assign root_cur[k] = root_reg[k-1];
            assign rad_cur[k]  = rad_reg[k-1];
            assign tag_cur[k]  = tag_reg[k-1];
        end

        // Bring down the next two radicand bits and try root bit one.
        assign part         = {rem_cur[k][RW-3:0], rad_cur[k][AW-1 -: 2]};
        assign trial        = {root_cur[k], 2'b01};
        assign take         = part >= trial;
        assign rem_next[k]  = take ? part - trial : part;
        assign root_next[k] = {root_cur[k][SW-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SW; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < SW; k++)
            begin
                vld_reg[k] <= vld_cur[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < SW; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                rad_reg[k]  <= rad_cur[k] << 2;
                tag_reg[k]  <= tag_cur[k];
            end
        end
    end

    assign done_valid = vld_reg[SW-1];
    assign root       = root_reg[SW-1];
    assign done_tag   = tag_reg[SW-1];

endmodule

/* hdl/point_segment_distance.sv */
// Top level: projection of a point onto a segment and distance to the segment.
//
//  channel  | direction | words carried
//  ---------+-----------+-------------------------------------------------
//  query    | in        | point_x/y, start_x/y, end_x/y (signed coords)
//  result   | out       | position, distance, degenerate
//
// One word is taken every cycle while the output register is empty or being taken.
// The bit-serial divider and square root stages set the depth; their sizes follow
// from QW = 2*COORD_BITS + 3 + 2*DIST_FRAC_BITS and SW = (QW + 1) / 2.
// All stages advance together whenever the output register is empty or
// being taken, so a stall freezes the whole pipeline.
// Reset clears only the valid bits.
module point_segment_distance #(
    parameter int COORD_BITS     = 24,
    parameter int POS_FRAC_BITS  = 16,
    parameter int DIST_FRAC_BITS = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    psd_query_if.sink      query,
    psd_result_if.source   result
);

    localparam int DW  = COORD_BITS + 1;          // coordinate differences
    localparam int MW  = 2 * DW;                  // signed products
    localparam int PW  = 2 * COORD_BITS + 3;      // sums of squares, |cross|
    localparam int SPW = PW + 1;                  // signed dot and cross
    localparam int HW  = COORD_BITS + 2;          // low part of |cross|
    localparam int XW  = 2 * PW;                  // squared cross product
    localparam int QW  = PW + 2 * DIST_FRAC_BITS; // squared distance, scaled
    localparam int SW  = (QW + 1) / 2;            // distance root
    localparam int PF  = POS_FRAC_BITS;
    localparam int TW  = PF + 2;
    localparam int POS_W  = psd_pkg::POS_W;
    localparam int DIST_W = psd_pkg::DIST_W;

    logic en;
    logic res_vld_reg;

    assign en          = !res_vld_reg || result.ready;
    assign query.ready = en;

    // Stage 1: differences.
    logic                 v1_reg;
    logic signed [DW-1:0] dx_reg, dy_reg, vx_reg, vy_reg, wx_reg, wy_reg;

    // Stage 2: products.
    logic                 v2_reg;
    logic signed [MW-1:0] dxdx_reg, dydy_reg, vxvx_reg, vyvy_reg, wxwx_reg, wywy_reg;
    logic signed [MW-1:0] dxvx_reg, dyvy_reg, dxvy_reg, dyvx_reg;

    // Stage 3: sums.
    logic                  v3_reg;
    logic [PW-1:0]         len2_reg, vv_reg, ww_reg;
    logic signed [SPW-1:0] dot_reg, cross_reg;

    // Stage 4: case selection.
    logic                 v4_reg;
    psd_pkg::psd_flags_t  fl4_reg;
    logic [PW-1:0]        num4_reg, c4_reg, den4_reg, posr4_reg;

    // Stage 5: partial products of the squared cross product.
    logic                       v5_reg;
    psd_pkg::psd_flags_t        fl5_reg;
    logic [PW-1:0]              num5_reg, den5_reg, posr5_reg;
    logic [2*(PW-HW)-1:0]       hh5_reg;
    logic [PW-1:0]              hl5_reg;
    logic [2*HW-1:0]            ll5_reg;

    // Stage 6: divider operands.
    logic                 v6_reg;
    psd_pkg::psd_flags_t  fl6_reg;
    logic [PW-1:0]        rem6_reg, den6_reg, posr6_reg;
    logic [QW-1:0]        low6_reg;

    logic                 lo4, hi4;
    logic signed [SPW-1:0] cross_neg;
    logic [PW-HW-1:0]     c_hi;
    logic [HW-1:0]        c_lo;
    logic [XW-1:0]        x6;

    logic                 div_vld;
    logic [QW-1:0]        div_quot;
    logic [PF-1:0]        div_posq;
    psd_pkg::psd_flags_t  div_flags;
    logic [PF:0]          pos_full;

    logic                 sq_vld;
    logic [SW-1:0]        sq_root;
    logic [TW-1:0]        sq_tag;
    logic [PF+POS_W:0]    pos_ext;
    logic [SW+DIST_W-1:0] dist_ext;
    logic                 dist_sat;

    logic [POS_W-1:0]     position_reg;
    logic [DIST_W-1:0]    distance_reg;
    logic                 degenerate_reg;

    // A projection at or before the start, or a zero-length segment, measures
    // to the start point; one at or past the end measures to the end point.
    assign lo4       = (len2_reg == '0) || dot_reg[SPW-1] || (dot_reg == '0);
    assign hi4       = !lo4 && (dot_reg[PW-1:0] >= len2_reg);
    assign cross_neg = -cross_reg;
    assign c_hi      = c4_reg[PW-1:HW];
    assign c_lo      = c4_reg[HW-1:0];

    assign x6 = fl5_reg.interior
              ? (XW'(hh5_reg) << (2 * HW)) + (XW'(hl5_reg) << (HW + 1)) + XW'(ll5_reg)
              : XW'(num5_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg      <= query.valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            v5_reg      <= v4_reg;
            v6_reg      <= v5_reg;
            res_vld_reg <= sq_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg <= DW'(query.end_x)   - DW'(query.start_x);
            dy_reg <= DW'(query.end_y)   - DW'(query.start_y);
            vx_reg <= DW'(query.point_x) - DW'(query.start_x);
            vy_reg <= DW'(query.point_y) - DW'(query.start_y);
            wx_reg <= DW'(query.point_x) - DW'(query.end_x);
            wy_reg <= DW'(query.point_y) - DW'(query.end_y);

            dxdx_reg <= dx_reg * dx_reg;
            dydy_reg <= dy_reg * dy_reg;
            vxvx_reg <= vx_reg * vx_reg;
            vyvy_reg <= vy_reg * vy_reg;
            wxwx_reg <= wx_reg * wx_reg;
            wywy_reg <= wy_reg * wy_reg;
            dxvx_reg <= dx_reg * vx_reg;
            dyvy_reg <= dy_reg * vy_reg;
            dxvy_reg <= dx_reg * vy_reg;
            dyvx_reg <= dy_reg * vx_reg;

            len2_reg  <= PW'(dxdx_reg) + PW'(dydy_reg);
            vv_reg    <= PW'(vxvx_reg) + PW'(vyvy_reg);
            ww_reg    <= PW'(wxwx_reg) + PW'(wywy_reg);
            dot_reg   <= SPW'(dxvx_reg) + SPW'(dyvy_reg);
            cross_reg <= SPW'(dxvy_reg) - SPW'(dyvx_reg);

            fl4_reg.deg      <= (len2_reg == '0);
            fl4_reg.hi       <= hi4;
            fl4_reg.interior <= !lo4 && !hi4;
            num4_reg  <= lo4 ? vv_reg : (hi4 ? ww_reg : '0);
            c4_reg    <= cross_reg[SPW-1] ? cross_neg[PW-1:0] : cross_reg[PW-1:0];
            den4_reg  <= (!lo4 && !hi4) ? len2_reg : PW'(1);
            posr4_reg <= dot_reg[PW-1:0];

            fl5_reg   <= fl4_reg;
            num5_reg  <= num4_reg;
            den5_reg  <= den4_reg;
            posr5_reg <= posr4_reg;
            hh5_reg   <= c_hi * c_hi;
            hl5_reg   <= c_hi * c_lo;
            ll5_reg   <= c_lo * c_lo;

            // The quotient is known to fit in QW bits, so the bits above it
            // start out as the partial remainder.
            fl6_reg   <= fl5_reg;
            den6_reg  <= den5_reg;
            posr6_reg <= posr5_reg;
            rem6_reg  <= x6[XW-1:PW];
            low6_reg  <= QW'(x6[PW-1:0]) << (2 * DIST_FRAC_BITS);

            position_reg   <= pos_ext[POS_W-1:0];
            distance_reg   <= dist_sat ? '1 : dist_ext[DIST_W-1:0];
            degenerate_reg <= sq_tag[0];
        end
    end

    psd_div #(
        .PW (PW),
        .QW (QW),
        .PF (PF)
    ) u_div (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .start_valid   (v6_reg),
        .remainder     (rem6_reg),
        .dividend_low  (low6_reg),
        .divisor       (den6_reg),
        .pos_remainder (posr6_reg),
        .flags         (fl6_reg),
        .done_valid    (div_vld),
        .quotient      (div_quot),
        .pos_quotient  (div_posq),
        .done_flags    (div_flags)
    );

    assign pos_full = div_flags.hi       ? ((PF+1)'(1) << PF)
                    : div_flags.interior ? {1'b0, div_posq}
                    : '0;

    psd_sqrt #(
        .QW (QW),
        .SW (SW),
        .TW (TW)
    ) u_sqrt (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .start_valid (div_vld),
        .radicand    (div_quot),
        .tag         ({pos_full, div_flags.deg}),
        .done_valid  (sq_vld),
        .root        (sq_root),
        .done_tag    (sq_tag)
    );

    assign pos_ext  = (PF+POS_W+1)'(sq_tag[TW-1:1]);
    assign dist_ext = (SW+DIST_W)'(sq_root);
    assign dist_sat = |dist_ext[SW+DIST_W-1:DIST_W];

    assign result.valid      = res_vld_reg;
    assign result.position   = position_reg;
    assign result.distance   = distance_reg;
    assign result.degenerate = degenerate_reg;

endmodule
